[src/sme_pkg.sv]
// Shared types and constants for the set membership engine.
package sme_pkg;

   // Operation codes carried in the input item's tuser field.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LOOKUP_MODE   = 2'd0;
   localparam logic [1:0] CSR_INVERT_ANSWER = 2'd1;
   localparam logic [1:0] CSR_RANGE_MIN     = 2'd2;
   localparam logic [1:0] CSR_RANGE_MAX     = 2'd3;

   // Reset values of the range registers.
   localparam logic signed [63:0] RANGE_MIN_RESET = 64'sd0;
   localparam logic signed [63:0] RANGE_MAX_RESET = 64'sd4095;

   // Width of one bitmap memory row and its bit-select width.
   localparam int ROW_BITS  = 32;
   localparam int ROW_SEL_W = 5;

   // Number of cell match bits folded into one registered group.
   localparam int GROUP_SIZE = 32;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_SWEEP = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_CMP   = 5'b00100,
      ST_RED   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Controls broadcast to every cell of the sorted chain.
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
   } cell_ctl_type;

endpackage

[src/sme_cell.sv]
// One cell of the sorted store chain: holds one entry, compares it and shifts on insert.
module sme_cell (
   input  logic                  clock,
   input  sme_pkg::cell_ctl_type ctl,
   input  logic signed [63:0]    key,
   input  logic                  cell_valid,
   input  logic signed [63:0]    prev_entry,
   input  logic                  prev_less,
   output logic signed [63:0]    entry_ff,
   output logic                  less_ff,
   output logic                  match_ff
);

   // Compare the held entry against the broadcast key.
   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         less_ff  <= cell_valid && (entry_ff < key);
         match_ff <= cell_valid && (entry_ff == key);
      end
   end

   // On insert, cells at or above the insert point take the key or the left neighbor's entry.
   always_ff @(posedge clock) begin
      if (ctl.ins_en && !less_ff) begin
         entry_ff <= prev_less ? key : prev_entry;
      end
   end

endmodule

[src/sme_bitmap.sv]
// Presence bitmap memory, one row of bits per address, registered read.
module sme_bitmap #(
   parameter int ROWS   = 128,
   parameter int ADDR_W = 7
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [sme_pkg::ROW_BITS-1:0] rd_data_ff,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [sme_pkg::ROW_BITS-1:0] wr_data
);

   logic [sme_pkg::ROW_BITS-1:0] mem [ROWS];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[src/set_membership_engine.sv]
// Top level of the set membership engine: sequencer, sorted cell chain and bitmap.
//
//   channel   direction  handshake             payload
//   req_      in         req_tvalid/tready     tdata value, tuser operation, tlast last
//   rsp_      out        rsp_tvalid/tready     tdata found and status, tlast last_out
//   csr_      in         csr_wr_en             csr_index, csr_wdata
//
// Each item goes through accept, cell compare and range check, match group reduction
// with bitmap row read, then commit and result load.
// A clear item adds a bitmap sweep, one memory row a cycle.
// After reset the same sweep runs before the first item.
// A result waiting on rsp_tready holds the next item in its commit cycle.
module set_membership_engine #(
   parameter int SET_DEPTH  = 1024,
   parameter int TABLE_SIZE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // Input item: tdata[63:0] value; tuser[1:0] operation.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   // Result item: tdata[0] found, tdata[2:1] status, tdata[7:3] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CNT_W   = $clog2(SET_DEPTH + 1);
   localparam int GROUPS  = (SET_DEPTH + sme_pkg::GROUP_SIZE - 1) / sme_pkg::GROUP_SIZE;
   localparam int PAD_N   = GROUPS * sme_pkg::GROUP_SIZE;
   localparam int OFF_W   = $clog2(TABLE_SIZE);
   localparam int ROWS    = (TABLE_SIZE + sme_pkg::ROW_BITS - 1) / sme_pkg::ROW_BITS;
   localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Configuration registers.
   logic               mode_ff;
   logic               invert_ff;
   logic signed [63:0] rmin_ff;
   logic signed [63:0] rmax_ff;

   // Sequencer and item registers.
   sme_pkg::state_type state_ff, state_in;
   logic [ROW_AW-1:0]  sweep_ff;
   logic [1:0]         op_ff;
   logic signed [63:0] value_ff;
   logic               last_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               in_tab_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [GROUPS-1:0]  grp_ff;
   logic [GROUPS-1:0]  grp_in;

   // Result registers.
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_last_ff;

   // Chain signals.
   sme_pkg::cell_ctl_type cell_ctl;
   logic signed [63:0] entry_vec [SET_DEPTH];
   logic [SET_DEPTH-1:0] less_vec;
   logic [PAD_N-1:0]   match_pad;

   // Commit-cycle decisions.
   logic               done_go;
   logic               is_insert;
   logic               is_query;
   logic               is_clear;
   logic               store_hit;
   logic               tab_hit;
   logic               store_full;
   logic               store_ins;
   logic               tab_ins;
   logic               found;
   logic [1:0]         status;

   // Range check for the bitmap.
   logic               range_empty;
   logic               range_ok;
   logic [63:0]        diff;
   logic               in_tab;

   // Bitmap port signals.
   logic [sme_pkg::ROW_BITS-1:0] rd_data_ff;
   logic               wr_en;
   logic [ROW_AW-1:0]  wr_addr;
   logic [ROW_AW-1:0]  row_addr;
   logic [sme_pkg::ROW_BITS-1:0] wr_data;
   logic [sme_pkg::ROW_SEL_W-1:0] bit_sel;

   assign req_tready = (state_ff == sme_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         invert_ff <= 1'b0;
         rmin_ff   <= sme_pkg::RANGE_MIN_RESET;
         rmax_ff   <= sme_pkg::RANGE_MAX_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sme_pkg::CSR_LOOKUP_MODE:   mode_ff   <= csr_wdata[0];
            sme_pkg::CSR_INVERT_ANSWER: invert_ff <= csr_wdata[0];
            sme_pkg::CSR_RANGE_MIN:     rmin_ff   <= csr_wdata;
            sme_pkg::CSR_RANGE_MAX:     rmax_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode of the held item and the commit decisions.
   always_comb begin
      is_insert  = (op_ff == sme_pkg::OP_INSERT);
      is_query   = (op_ff == sme_pkg::OP_QUERY);
      is_clear   = (op_ff == sme_pkg::OP_CLEAR);
      done_go    = (state_ff == sme_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
      bit_sel    = sme_pkg::ROW_SEL_W'(off_ff);
      store_hit  = |grp_ff;
      tab_hit    = in_tab_ff && rd_data_ff[bit_sel];
      store_full = (count_ff == CNT_W'(SET_DEPTH));
      store_ins  = is_insert && !mode_ff && !store_hit && !store_full;
      tab_ins    = is_insert && mode_ff && in_tab_ff;
      if (is_insert && !mode_ff && !store_hit && store_full) begin
         status = sme_pkg::STS_FULL;
      end else if (is_insert && mode_ff && !in_tab_ff) begin
         status = sme_pkg::STS_RANGE;
      end else begin
         status = sme_pkg::STS_OK;
      end
      if (is_query) begin
         found = (mode_ff ? tab_hit : store_hit) ^ invert_ff;
      end else begin
         found = 1'b0;
      end
   end

   // Bitmap offset of the held value against the current range.
   always_comb begin
      range_empty = (rmax_ff < rmin_ff);
      range_ok    = !range_empty && (value_ff >= rmin_ff) && (value_ff <= rmax_ff);
      diff        = 64'(value_ff) - 64'(rmin_ff);
      in_tab      = range_ok && (diff < 64'(TABLE_SIZE));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sme_pkg::ST_SWEEP: begin
            if (sweep_ff == ROW_AW'(ROWS - 1)) state_in = sme_pkg::ST_IDLE;
         end
         sme_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sme_pkg::ST_CMP;
         end
         sme_pkg::ST_CMP:  state_in = sme_pkg::ST_RED;
         sme_pkg::ST_RED:  state_in = sme_pkg::ST_DONE;
         sme_pkg::ST_DONE: begin
            if (done_go) state_in = is_clear ? sme_pkg::ST_SWEEP : sme_pkg::ST_IDLE;
         end
         default: state_in = sme_pkg::ST_SWEEP;
      endcase
   end

   // Sequencer, sweep counter and store fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::ST_SWEEP;
         sweep_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == sme_pkg::ST_SWEEP) begin
            sweep_ff <= sweep_ff + 1'b1;
         end else begin
            sweep_ff <= '0;
         end
         if (done_go && is_clear) begin
            count_ff <= '0;
         end else if (done_go && store_ins) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Item capture, range check and match reduction registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         value_ff <= req_tdata;
         last_ff  <= req_tlast;
      end
      if (state_ff == sme_pkg::ST_CMP) begin
         in_tab_ff <= in_tab;
         off_ff    <= diff[OFF_W-1:0];
      end
      if (state_ff == sme_pkg::ST_RED) begin
         grp_ff <= grp_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_go) begin
         rsp_data_ff <= {5'd0, status, found};
         rsp_last_ff <= last_ff;
      end
   end

   // Chain of cells holding the sorted store.
   assign cell_ctl.cmp_en = (state_ff == sme_pkg::ST_CMP);
   assign cell_ctl.ins_en = done_go && store_ins;

   for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
      logic signed [63:0] left_entry;
      logic               left_less;
      logic               valid;
      if (i == 0) begin : g_head
         assign left_entry = value_ff;
         assign left_less  = 1'b1;
      end else begin : g_body
         assign left_entry = entry_vec[i-1];
         assign left_less  = less_vec[i-1];
      end
      assign valid = (count_ff > CNT_W'(i));
      sme_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .key        (value_ff),
         .cell_valid (valid),
         .prev_entry (left_entry),
         .prev_less  (left_less),
         .entry_ff   (entry_vec[i]),
         .less_ff    (less_vec[i]),
         .match_ff   (match_pad[i])
      );
   end

   for (genvar i = SET_DEPTH; i < PAD_N; i++) begin : g_pad
      assign match_pad[i] = 1'b0;
   end

   // First level of the match tree: one OR per group of cells.
   for (genvar g = 0; g < GROUPS; g++) begin : g_grp
      assign grp_in[g] = |match_pad[g*sme_pkg::GROUP_SIZE +: sme_pkg::GROUP_SIZE];
   end

   // Bitmap port: sweep writes zero rows, inserts write back the row with one bit set.
   always_comb begin
      row_addr = ROW_AW'(off_ff >> sme_pkg::ROW_SEL_W);
      if (state_ff == sme_pkg::ST_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '0;
      end else begin
         wr_en   = done_go && tab_ins;
         wr_addr = row_addr;
         wr_data = rd_data_ff | (sme_pkg::ROW_BITS'(1) << bit_sel);
      end
   end

   sme_bitmap #(
      .ROWS   (ROWS),
      .ADDR_W (ROW_AW)
   ) u_bitmap (
      .clock      (clock),
      .rd_en      (state_ff == sme_pkg::ST_RED),
      .rd_addr    (row_addr),
      .rd_data_ff (rd_data_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SET_DEPTH))
      else $error("store count above depth");

   // The fill count moves by at most one per cycle or drops to zero.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $past(reset) || count_ff == $past(count_ff) || count_ff == '0 ||
      count_ff == $past(count_ff) + 1'b1)
      else $error("store count jumped");

   // An accepted item always moves on to the compare cycle.
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == sme_pkg::ST_CMP)
      else $error("accepted item not compared");

   // The head of the chain stays strictly ascending.
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sme_pkg::ST_IDLE && count_ff >= CNT_W'(2)) |->
      entry_vec[0] < entry_vec[1])
      else $error("sorted store out of order");

endmodule

[tb/tb_set_membership_engine.sv]
// Self-checking testbench for the set membership engine: directed table, then random phases.
module tb_set_membership_engine;

   localparam int STORE_DEPTH  = 1024;
   localparam int BITMAP_SIZE  = 4096;
   localparam int SLOT_W       = $clog2(BITMAP_SIZE);
   // Bitmap sweep after a clear, plus margin, used as the settle time before register writes.
   localparam int SETTLE_CYCLES = BITMAP_SIZE / sme_pkg::ROW_BITS + 16;
   localparam int IDLE_PCT     = 31;
   localparam int MAX_REPORTS  = 10;
   localparam int RECENT_DEPTH = 48;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic       MODE_SORTED = 1'b0;
   localparam logic       MODE_TABLE  = 1'b1;

   localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   // One expected or observed result item.
   typedef struct packed {
      logic                status_last_pad_unused;
      logic                found;
      sme_pkg::status_type status;
      logic                last;
   } answer_full_type;

   typedef struct packed {
      logic                found;
      sme_pkg::status_type status;
      logic                last;
   } answer_type;

   // Directed rows are either an item or a register write (code is then the index).
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        code;
      logic signed [63:0] value;
      logic              last;
      logic              typed;
      logic              found;
      logic [1:0]        status;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] value
   logic [1:0]  req_tuser = '0;   // [1:0] operation
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] found, [2:1] status, [7:3] zero
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Predictor state and its copy of the registers.
   bit                     member_set [longint];
   bit [BITMAP_SIZE-1:0]   presence;
   logic                   cfg_mode;
   logic                   cfg_invert;
   logic signed [63:0]     cfg_range_min;
   logic signed [63:0]     cfg_range_max;

   answer_type             pending_answers [$];
   logic signed [63:0]     recent_values [$];
   int                     error_count = 0;
   bit                     steady = 1'b0;
   bit                     settled = 1'b1;

   row_type directed_rows [0:31] = '{
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd0,    1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, VAL_MIN,   1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, VAL_MAX,   1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, VAL_MAX,   1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  VAL_MIN,   1'b0, 1'b1, 1'b1, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  VAL_MAX,   1'b1, 1'b1, 1'b1, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  -64'sd1,   1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, OP_UNUSED,          -64'sd1,   1'b1, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_CLEAR,  64'sd0,    1'b1, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  VAL_MAX,   1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_CSR,  sme_pkg::CSR_LOOKUP_MODE, 64'sd1, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, 64'sd0,    1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, 64'sd4095, 1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, 64'sd4096, 1'b0, 1'b1, 1'b0, sme_pkg::STS_RANGE},
      '{ROW_ITEM, sme_pkg::OP_INSERT, -64'sd1,   1'b0, 1'b1, 1'b0, sme_pkg::STS_RANGE},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd4095, 1'b1, 1'b1, 1'b1, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd4096, 1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_CSR,  sme_pkg::CSR_INVERT_ANSWER, 64'sd1, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd0,    1'b0, 1'b1, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd1,    1'b1, 1'b1, 1'b1, sme_pkg::STS_OK},
      '{ROW_CSR,  sme_pkg::CSR_RANGE_MIN, VAL_MIN, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_CSR,  sme_pkg::CSR_RANGE_MAX, VAL_MAX, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, VAL_MIN,   1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, 64'sh8000_0000_0000_1000, 1'b0, 1'b1, 1'b0,
        sme_pkg::STS_RANGE},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sh8000_0000_0000_0FFF, 1'b1, 1'b0, 1'b0,
        sme_pkg::STS_OK},
      '{ROW_CSR,  sme_pkg::CSR_RANGE_MIN, 64'sd5, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_CSR,  sme_pkg::CSR_RANGE_MAX, 64'sd4, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd5,    1'b0, 1'b1, 1'b1, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_INSERT, 64'sd5,    1'b1, 1'b1, 1'b0, sme_pkg::STS_RANGE},
      '{ROW_CSR,  sme_pkg::CSR_LOOKUP_MODE, 64'sd0, 1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_QUERY,  64'sd0,    1'b0, 1'b0, 1'b0, sme_pkg::STS_OK},
      '{ROW_ITEM, sme_pkg::OP_CLEAR,  -64'sd1,   1'b1, 1'b1, 1'b0, sme_pkg::STS_OK}
   };

   set_membership_engine #(
      .SET_DEPTH  (STORE_DEPTH),
      .TABLE_SIZE (BITMAP_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic signed [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [63:0] pick_recent();
      if (recent_values.size() == 0) return rand64();
      return recent_values[$urandom_range(recent_values.size() - 1)];
   endfunction

   function automatic void note_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
   endfunction

   // Bitmap position of a value under the current range, if it is covered at all.
   function automatic bit bitmap_slot(logic signed [63:0] v, output logic [SLOT_W-1:0] slot);
      logic [63:0] offset;
      slot = '0;
      if (cfg_range_max < cfg_range_min || v < cfg_range_min || v > cfg_range_max)
         return 1'b0;
      offset = v - cfg_range_min;
      if (offset >= 64'(BITMAP_SIZE)) return 1'b0;
      slot = offset[SLOT_W-1:0];
      return 1'b1;
   endfunction

   // Applies one item to the predicted set and returns the result it must produce.
   function automatic answer_type predict_answer(logic [1:0] op, logic signed [63:0] v,
                                                 logic last);
      answer_type        ans;
      logic [SLOT_W-1:0] slot;
      bit                hit;
      ans.found  = 1'b0;
      ans.status = sme_pkg::STS_OK;
      ans.last   = last;
      hit = 1'b0;
      case (op)
         sme_pkg::OP_INSERT: begin
            if (cfg_mode == MODE_SORTED) begin
               // A value already present is fine even when the store is full.
               if (!member_set.exists(v)) begin
                  if (member_set.num() >= STORE_DEPTH) ans.status = sme_pkg::STS_FULL;
                  else member_set[v] = 1'b1;
               end
            end else if (bitmap_slot(v, slot)) begin
               presence[slot] = 1'b1;
            end else begin
               ans.status = sme_pkg::STS_RANGE;
            end
         end
         sme_pkg::OP_QUERY: begin
            if (cfg_mode == MODE_SORTED) hit = member_set.exists(v);
            else if (bitmap_slot(v, slot)) hit = presence[slot];
            ans.found = hit ^ cfg_invert;
         end
         sme_pkg::OP_CLEAR: begin
            member_set.delete();
            presence = '0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Sends one item, holding it until accepted, and records what it must produce.
   task automatic push_item(input logic [1:0] op, input logic signed [63:0] v,
                            input logic last, input bit typed, input answer_type typed_ans);
      answer_type ans;
      settled = 1'b0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= op;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ans = predict_answer(op, v, last);
      if (typed) ans = typed_ans;
      pending_answers.push_back(ans);
      recent_values.push_back(v);
      if (recent_values.size() > RECENT_DEPTH) void'(recent_values.pop_front());
   endtask

   // Waits for every outstanding result and for any bitmap sweep to finish.
   task automatic settle();
      if (!settled) begin
         req_tvalid <= 1'b0;
         while (pending_answers.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         settled = 1'b1;
      end
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         sme_pkg::CSR_LOOKUP_MODE:   cfg_mode      = data[0];
         sme_pkg::CSR_INVERT_ANSWER: cfg_invert    = data[0];
         sme_pkg::CSR_RANGE_MIN:     cfg_range_min = data;
         sme_pkg::CSR_RANGE_MAX:     cfg_range_max = data;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic invert,
                            input logic signed [63:0] lo, input logic signed [63:0] hi);
      settle();
      write_csr(sme_pkg::CSR_LOOKUP_MODE, 64'(mode));
      write_csr(sme_pkg::CSR_INVERT_ANSWER, 64'(invert));
      write_csr(sme_pkg::CSR_RANGE_MIN, lo);
      write_csr(sme_pkg::CSR_RANGE_MAX, hi);
   endtask

   // Values aimed at the current mode: bitmap edges in table mode, repeats and extremes in sorted mode.
   function automatic logic signed [63:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (cfg_mode == MODE_TABLE) begin
         if (r < 6) return cfg_range_min + 64'($urandom_range(BITMAP_SIZE + 3));
         if (r == 6) return cfg_range_max + 64'sd1 - 64'($urandom_range(3));
         if (r == 7) return rand64();
         return pick_recent();
      end
      if (r < 4) return pick_recent();
      if (r == 4) return VAL_MIN;
      if (r == 5) return VAL_MAX;
      if (r == 6) return $signed(64'($urandom_range(3))) - 64'sd2;
      return rand64();
   endfunction

   // Mixed operations under one register setting.
   task automatic run_phase(input logic mode, input logic invert,
                            input logic signed [63:0] lo, input logic signed [63:0] hi,
                            input int count, input bit no_idle);
      int r;
      configure(mode, invert, lo, hi);
      steady = no_idle;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 46)
            push_item(sme_pkg::OP_INSERT, pick_value(), 1'($urandom_range(1)), 1'b0, '0);
         else if (r < 90)
            push_item(sme_pkg::OP_QUERY, pick_value(), 1'($urandom_range(1)), 1'b0, '0);
         else if (r < 95)
            push_item(sme_pkg::OP_CLEAR, rand64(), 1'($urandom_range(1)), 1'b0, '0);
         else
            push_item(OP_UNUSED, rand64(), 1'($urandom_range(1)), 1'b0, '0);
      end
      steady = 1'b0;
   endtask

   // Sorted store filled to capacity, then pushed past it with new and repeated values.
   task automatic fill_store();
      int extra;
      int r;
      logic signed [63:0] v;
      configure(MODE_SORTED, 1'b0, sme_pkg::RANGE_MIN_RESET, sme_pkg::RANGE_MAX_RESET);
      extra = 0;
      while (extra < 20) begin
         r = $urandom_range(99);
         if (member_set.num() < STORE_DEPTH) begin
            // Fresh values while the store fills, with an occasional lookup.
            if (r < 97)
               push_item(sme_pkg::OP_INSERT, rand64(), 1'($urandom_range(1)), 1'b0, '0);
            else
               push_item(sme_pkg::OP_QUERY, pick_recent(), 1'($urandom_range(1)), 1'b0, '0);
         end else begin
            extra++;
            if (r < 70) begin
               v = ($urandom_range(99) < 50) ? rand64() : pick_recent();
               push_item(sme_pkg::OP_INSERT, v, 1'($urandom_range(1)), 1'b0, '0);
            end else if (r < 95) begin
               push_item(sme_pkg::OP_QUERY, pick_recent(), 1'($urandom_range(1)), 1'b0, '0);
            end else begin
               push_item(OP_UNUSED, rand64(), 1'($urandom_range(1)), 1'b0, '0);
            end
         end
      end
   endtask

   // Result side: random back-pressure and in-order comparison.
   always @(posedge clock) begin : collect
      answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               note_mismatch($sformatf("result with nothing expected, tdata %h", rsp_tdata));
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tdata[0] !== want.found)
                  note_mismatch($sformatf("found: expected %0d, got %0d",
                                          want.found, rsp_tdata[0]));
               if (rsp_tdata[2:1] !== want.status)
                  note_mismatch($sformatf("status: expected %0d, got %0d",
                                          want.status, rsp_tdata[2:1]));
               if (rsp_tlast !== want.last)
                  note_mismatch($sformatf("last: expected %0d, got %0d",
                                          want.last, rsp_tlast));
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin : stimulus
      answer_type typed_ans;
      presence      = '0;
      cfg_mode      = MODE_SORTED;
      cfg_invert    = 1'b0;
      cfg_range_min = sme_pkg::RANGE_MIN_RESET;
      cfg_range_max = sme_pkg::RANGE_MAX_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, every operation and the range corner cases.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            write_csr(directed_rows[i].code, directed_rows[i].value);
         end else begin
            typed_ans.found  = directed_rows[i].found;
            typed_ans.status = sme_pkg::status_type'(directed_rows[i].status);
            typed_ans.last   = directed_rows[i].last;
            push_item(directed_rows[i].code, directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, typed_ans);
         end
      end

      // Random phases; no clear between table phases so bits survive a range move.
      fill_store();
      run_phase(MODE_SORTED, 1'b1, sme_pkg::RANGE_MIN_RESET, sme_pkg::RANGE_MAX_RESET,
                12, 1'b0);
      run_phase(MODE_TABLE, 1'b0, sme_pkg::RANGE_MIN_RESET, sme_pkg::RANGE_MAX_RESET,
                20, 1'b0);
      run_phase(MODE_TABLE, 1'b1, VAL_MIN, VAL_MAX, 12, 1'b0);
      run_phase(MODE_TABLE, 1'b0, VAL_MAX - 64'sd3000, VAL_MAX, 12, 1'b0);
      run_phase(MODE_TABLE, 1'b0, -64'sd100, 64'sd50, 10, 1'b0);
      run_phase(MODE_TABLE, 1'b1, 64'sd100, -64'sd100, 10, 1'b0);
      begin : random_range
         logic signed [63:0] lo;
         lo = rand64();
         run_phase(MODE_TABLE, 1'b0, lo, lo + 64'($urandom_range(8000)), 36, 1'b1);
      end
      run_phase(MODE_SORTED, 1'b0, sme_pkg::RANGE_MIN_RESET, sme_pkg::RANGE_MAX_RESET,
                12, 1'b0);

      settle();
      if (error_count == 0 && pending_answers.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[set_membership_engine.f]
src/sme_pkg.sv
src/sme_cell.sv
src/sme_bitmap.sv
src/set_membership_engine.sv
tb/tb_set_membership_engine.sv
